/* src/rbbe_pkg.sv */
// rbbe_pkg: shared types and constants of the ray box boundary extend unit
// no dependencies

package rbbe_pkg;

    localparam int DIV_W    = 51;
    localparam int DEN_W    = 18;
    localparam int Q_DEPTH  = 4;
    localparam int Q_AW     = 2;
    localparam int SUM_W    = 53;

    localparam logic [1:0] REG_X_LOW  = 2'd0;
    localparam logic [1:0] REG_X_HIGH = 2'd1;
    localparam logic [1:0] REG_Y_LOW  = 2'd2;
    localparam logic [1:0] REG_Y_HIGH = 2'd3;

    localparam logic [31:0] RST_X_LOW  = 32'd0;
    localparam logic [31:0] RST_X_HIGH = 32'd6225920;
    localparam logic [31:0] RST_Y_LOW  = 32'hFFF7_0000;
    localparam logic [31:0] RST_Y_HIGH = 32'd3145728;

    typedef struct packed {
        logic signed [31:0] x_low;
        logic signed [31:0] x_high;
        logic signed [31:0] y_low;
        logic signed [31:0] y_high;
    } box_t;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [15:0] heading_x;
        logic signed [15:0] heading_y;
    } ray_in_t;

    typedef struct packed {
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic               hit;
    } ray_out_t;

    typedef struct packed {
        logic               hit;
        logic               is_x;
        logic signed [48:0] off;
        logic [16:0]        mag;
        logic signed [31:0] bound;
        logic signed [31:0] oth;
    } seg_item_t;

endpackage

/* src/rbbe_front.sv */
// rbbe_front: side classification pipeline, picks the nearest qualifying side
// depends on rbbe_pkg

module rbbe_front import rbbe_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  box_t      box,
    input  logic      in_valid,
    output logic      in_ready,
    input  ray_in_t   in_data,
    output logic      item_valid,
    input  logic      item_ready,
    output seg_item_t item
);

    logic [7:0] vld_reg;
    logic       en;

    ray_in_t            s0_reg;
    logic signed [31:0] org_x_reg [6];
    logic signed [31:0] org_y_reg [6];

    logic [32:0]        n1_next [4];
    logic [16:0]        mag1_next [4];
    logic               nz1_next [4];
    logic [32:0]        dlo1_next [4];
    logic [32:0]        dhi1_next [4];
    logic [15:0]        dot1_next [4];

    logic signed [32:0] n1_reg [4];
    logic [16:0]        mag1_reg [4];
    logic               nz1_reg [4];
    logic signed [32:0] dlo1_reg [4];
    logic signed [32:0] dhi1_reg [4];
    logic signed [15:0] dot1_reg [4];

    logic signed [48:0] off2_next [4];
    logic signed [50:0] lom2_next [4];
    logic signed [50:0] him2_next [4];
    logic signed [48:0] off2_reg [4];
    logic signed [50:0] lom2_reg [4];
    logic signed [50:0] him2_reg [4];
    logic               pos2_reg [4];
    logic [32:0]        n2_reg [4];
    logic [16:0]        mag2_reg [4];

    logic               cond3_reg [4];
    logic [32:0]        n3_reg [4];
    logic [16:0]        mag3_reg [4];
    logic signed [48:0] off3_reg [4];

    logic [49:0]        pr4_reg [4];
    logic               cond4_reg [4];
    logic [32:0]        n4_reg [4];
    logic [16:0]        mag4_reg [4];
    logic signed [48:0] off4_reg [4];

    logic               sel_r, sel_t;
    logic               cond5_reg [2];
    logic               side5_reg [2];
    logic [32:0]        n5_reg [2];
    logic [16:0]        mag5_reg [2];
    logic signed [48:0] off5_reg [2];

    logic [49:0]        q6_reg [2];
    logic               cond6_reg [2];
    logic               side6_reg [2];
    logic [16:0]        mag6_reg [2];
    logic signed [48:0] off6_reg [2];

    logic               sel_b;
    seg_item_t          item_next;
    seg_item_t          item_reg;

    assign en         = !vld_reg[7] || item_ready;
    assign in_ready   = en;
    assign item_valid = vld_reg[7];
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[6:0], in_valid};
        end
    end

    // per-side numerator, direction magnitude and other-axis range deltas
    always_comb
    begin
        logic [31:0] bnd, o_ax, o_ot, lo, hi;
        logic [15:0] d_ax, d_ot;
        logic [32:0] nraw;
        for (int i = 0; i < 4; i++)
        begin
            if (i < 2)
            begin
                o_ax = s0_reg.start_x;
                d_ax = s0_reg.heading_x;
                o_ot = s0_reg.start_y;
                d_ot = s0_reg.heading_y;
                lo   = box.y_low;
                hi   = box.y_high;
            end
            else
            begin
                o_ax = s0_reg.start_y;
                d_ax = s0_reg.heading_y;
                o_ot = s0_reg.start_x;
                d_ot = s0_reg.heading_x;
                lo   = box.x_low;
                hi   = box.x_high;
            end
            bnd = (i == 0) ? box.x_low : (i == 1) ? box.x_high :
                  (i == 2) ? box.y_low : box.y_high;
            nraw = {bnd[31], bnd} - {o_ax[31], o_ax};
            n1_next[i]   = d_ax[15] ? (33'd0 - nraw) : nraw;
            mag1_next[i] = d_ax[15] ? (17'd0 - {d_ax[15], d_ax}) : {d_ax[15], d_ax};
            nz1_next[i]  = (d_ax != 16'd0);
            dlo1_next[i] = {lo[31], lo} - {o_ot[31], o_ot};
            dhi1_next[i] = {hi[31], hi} - {o_ot[31], o_ot};
            dot1_next[i] = d_ot;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            off2_next[i] = n1_reg[i] * dot1_reg[i];
            lom2_next[i] = dlo1_reg[i] * $signed({1'b0, mag1_reg[i]});
            him2_next[i] = dhi1_reg[i] * $signed({1'b0, mag1_reg[i]});
        end
    end

    always_comb
    begin
        sel_r = cond4_reg[1] && (!cond4_reg[0] || (pr4_reg[0] < pr4_reg[1]));
        sel_t = cond4_reg[3] && (!cond4_reg[2] || (pr4_reg[2] < pr4_reg[3]));
    end

    always_comb
    begin
        sel_b = cond6_reg[1] && (!cond6_reg[0] || (q6_reg[0] < q6_reg[1]));
        if (sel_b)
        begin
            item_next.hit   = 1'b1;
            item_next.is_x  = 1'b0;
            item_next.bound = side6_reg[1] ? box.y_high : box.y_low;
            item_next.oth   = org_x_reg[5];
            item_next.off   = off6_reg[1];
            item_next.mag   = mag6_reg[1];
        end
        else if (cond6_reg[0])
        begin
            item_next.hit   = 1'b1;
            item_next.is_x  = 1'b1;
            item_next.bound = side6_reg[0] ? box.x_high : box.x_low;
            item_next.oth   = org_y_reg[5];
            item_next.off   = off6_reg[0];
            item_next.mag   = mag6_reg[0];
        end
        else
        begin
            item_next.hit   = 1'b0;
            item_next.is_x  = 1'b1;
            item_next.bound = org_x_reg[5];
            item_next.oth   = org_y_reg[5];
            item_next.off   = '0;
            item_next.mag   = 17'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_reg       <= in_data;
            org_x_reg[0] <= s0_reg.start_x;
            org_y_reg[0] <= s0_reg.start_y;
            for (int k = 1; k < 6; k++)
            begin
                org_x_reg[k] <= org_x_reg[k-1];
                org_y_reg[k] <= org_y_reg[k-1];
            end
            for (int i = 0; i < 4; i++)
            begin
                n1_reg[i]   <= $signed(n1_next[i]);
                mag1_reg[i] <= mag1_next[i];
                nz1_reg[i]  <= nz1_next[i];
                dlo1_reg[i] <= $signed(dlo1_next[i]);
                dhi1_reg[i] <= $signed(dhi1_next[i]);
                dot1_reg[i] <= $signed(dot1_next[i]);

                off2_reg[i] <= off2_next[i];
                lom2_reg[i] <= lom2_next[i];
                him2_reg[i] <= him2_next[i];
                pos2_reg[i] <= nz1_reg[i] && (n1_reg[i] > 33'sd0);
                n2_reg[i]   <= n1_reg[i];
                mag2_reg[i] <= mag1_reg[i];

                cond3_reg[i] <= pos2_reg[i] && (off2_reg[i] >= lom2_reg[i])
                                && (off2_reg[i] <= him2_reg[i]);
                n3_reg[i]    <= n2_reg[i];
                mag3_reg[i]  <= mag2_reg[i];
                off3_reg[i]  <= off2_reg[i];

                cond4_reg[i] <= cond3_reg[i];
                n4_reg[i]    <= n3_reg[i];
                mag4_reg[i]  <= mag3_reg[i];
                off4_reg[i]  <= off3_reg[i];
            end
            pr4_reg[0] <= n3_reg[1] * mag3_reg[0];
            pr4_reg[1] <= n3_reg[0] * mag3_reg[1];
            pr4_reg[2] <= n3_reg[3] * mag3_reg[2];
            pr4_reg[3] <= n3_reg[2] * mag3_reg[3];

            cond5_reg[0] <= sel_r || cond4_reg[0];
            side5_reg[0] <= sel_r;
            n5_reg[0]    <= sel_r ? n4_reg[1] : n4_reg[0];
            mag5_reg[0]  <= sel_r ? mag4_reg[1] : mag4_reg[0];
            off5_reg[0]  <= sel_r ? off4_reg[1] : off4_reg[0];
            cond5_reg[1] <= sel_t || cond4_reg[2];
            side5_reg[1] <= sel_t;
            n5_reg[1]    <= sel_t ? n4_reg[3] : n4_reg[2];
            mag5_reg[1]  <= sel_t ? mag4_reg[3] : mag4_reg[2];
            off5_reg[1]  <= sel_t ? off4_reg[3] : off4_reg[2];

            q6_reg[0] <= n5_reg[1] * mag5_reg[0];
            q6_reg[1] <= n5_reg[0] * mag5_reg[1];
            for (int j = 0; j < 2; j++)
            begin
                cond6_reg[j] <= cond5_reg[j];
                side6_reg[j] <= side5_reg[j];
                mag6_reg[j]  <= mag5_reg[j];
                off6_reg[j]  <= off5_reg[j];
            end

            item_reg <= item_next;
        end
    end

endmodule

/* src/rbbe_queue.sv */
// rbbe_queue: short register queue between front and back
// depends on rbbe_pkg

module rbbe_queue import rbbe_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  seg_item_t push_data,
    output logic      pop_valid,
    input  logic      pop_ready,
    output seg_item_t pop_data
);

    seg_item_t       mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_reg, wr_next;
    logic [Q_AW-1:0] rd_reg, rd_next;
    logic [Q_AW:0]   cnt_reg, cnt_next;
    logic            push, pop;

    assign push_ready = (cnt_reg != (Q_AW+1)'(Q_DEPTH)) ? 1'b1 : 1'b0;
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = mem_reg[rd_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + {{Q_AW{1'b0}}, push} - {{Q_AW{1'b0}}, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (Q_AW+1)'(Q_DEPTH))
        else $error("queue count past depth");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0 && cnt_reg != (Q_AW+1)'(Q_DEPTH)) |-> (wr_reg != rd_reg))
        else $error("queue pointers disagree with count");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("queue count missed a push");

endmodule

/* src/rbbe_back.sv */
// rbbe_back: pipelined rounding divider, endpoint add and saturation
// depends on rbbe_pkg

module rbbe_back import rbbe_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  seg_item_t item,
    output logic      out_valid,
    input  logic      out_ready,
    output ray_out_t  out_data
);

    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(64'sd2147483648);

    logic [DIV_W:0]     vld_reg;
    logic [DIV_W-1:0]   dq_reg  [DIV_W+1];
    logic [DEN_W-1:0]   rem_reg [DIV_W+1];
    logic [DEN_W-1:0]   den_reg [DIV_W+1];
    logic               neg_reg [DIV_W+1];
    logic               hit_reg [DIV_W+1];
    logic               isx_reg [DIV_W+1];
    logic [31:0]        bnd_reg [DIV_W+1];
    logic [31:0]        oth_reg [DIV_W+1];

    logic [DIV_W-1:0]   dq_nx  [DIV_W];
    logic [DEN_W-1:0]   rem_nx [DIV_W];

    logic [48:0]        mag_off;
    logic [DIV_W-1:0]   num0;
    logic               en;
    logic               out_valid_reg;
    ray_out_t           out_reg, out_next;

    assign en         = !out_valid_reg || out_ready;
    assign item_ready = en;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_reg;

    always_comb
    begin
        mag_off = item.off[48] ? (49'd0 - item.off) : item.off;
        num0    = {1'b0, mag_off, 1'b0} + {{(DIV_W-17){1'b0}}, item.mag};
    end

    // one quotient bit per stage
    always_comb
    begin
        logic [DEN_W:0] sh;
        logic           ge;
        for (int k = 0; k < DIV_W; k++)
        begin
            sh        = {rem_reg[k], dq_reg[k][DIV_W-1]};
            ge        = (sh >= {1'b0, den_reg[k]});
            rem_nx[k] = ge ? DEN_W'(sh - {1'b0, den_reg[k]}) : DEN_W'(sh);
            dq_nx[k]  = {dq_reg[k][DIV_W-2:0], ge};
        end
    end

    always_comb
    begin
        logic [SUM_W-1:0]        qs;
        logic signed [SUM_W-1:0] sum;
        logic [31:0]             ev;
        qs  = neg_reg[DIV_W] ? (SUM_W'(0) - {2'b00, dq_reg[DIV_W]})
                             : {2'b00, dq_reg[DIV_W]};
        sum = $signed({{(SUM_W-32){oth_reg[DIV_W][31]}}, oth_reg[DIV_W]} + qs);
        if (sum > SAT_MAX)
        begin
            ev = 32'h7FFF_FFFF;
        end
        else if (sum < SAT_MIN)
        begin
            ev = 32'h8000_0000;
        end
        else
        begin
            ev = sum[31:0];
        end
        out_next.hit = hit_reg[DIV_W];
        if (isx_reg[DIV_W])
        begin
            out_next.end_x = bnd_reg[DIV_W];
            out_next.end_y = ev;
        end
        else
        begin
            out_next.end_x = ev;
            out_next.end_y = bnd_reg[DIV_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[DIV_W-1:0], item_valid};
            out_valid_reg <= vld_reg[DIV_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dq_reg[0]  <= num0;
            rem_reg[0] <= '0;
            den_reg[0] <= {item.mag, 1'b0};
            neg_reg[0] <= item.off[48];
            hit_reg[0] <= item.hit;
            isx_reg[0] <= item.is_x;
            bnd_reg[0] <= item.bound;
            oth_reg[0] <= item.oth;
            for (int k = 0; k < DIV_W; k++)
            begin
                dq_reg[k+1]  <= dq_nx[k];
                rem_reg[k+1] <= rem_nx[k];
                den_reg[k+1] <= den_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                hit_reg[k+1] <= hit_reg[k];
                isx_reg[k+1] <= isx_reg[k];
                bnd_reg[k+1] <= bnd_reg[k];
                oth_reg[k+1] <= oth_reg[k];
            end
            out_reg <= out_next;
        end
    end

endmodule

/* src/ray_box_boundary_extend_unit.sv */
// ray_box_boundary_extend_unit: top level, box registers and apb port
// depends on rbbe_pkg, rbbe_front, rbbe_queue, rbbe_back
//
//   channel   direction  handshake           payload
//   in        input      in_valid/in_ready   ray_in_t  in_data
//   out       output     out_valid/out_ready ray_out_t out_data
//   config    apb        psel/penable/pready 32-bit box edges at 0x0..0xc
//
// one transfer per cycle in and out, sustained while out_ready stays high
// pipeline: 8 front stages, queue, 51-stage divider, output register
// reset clears all valids and loads the default box
// a stalled output holds the back pipeline; a full queue holds the front and in_ready

module ray_box_boundary_extend_unit import rbbe_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  ray_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output ray_out_t    out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    box_t      box_reg;
    logic      wr_en;
    logic      q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
    seg_item_t q_push_data, q_pop_data;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg.x_low  <= RST_X_LOW;
            box_reg.x_high <= RST_X_HIGH;
            box_reg.y_low  <= RST_Y_LOW;
            box_reg.y_high <= RST_Y_HIGH;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_X_LOW:  box_reg.x_low  <= pwdata;
                REG_X_HIGH: box_reg.x_high <= pwdata;
                REG_Y_LOW:  box_reg.y_low  <= pwdata;
                REG_Y_HIGH: box_reg.y_high <= pwdata;
                default:    box_reg.y_high <= box_reg.y_high;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_X_LOW:  prdata = box_reg.x_low;
            REG_X_HIGH: prdata = box_reg.x_high;
            REG_Y_LOW:  prdata = box_reg.y_low;
            REG_Y_HIGH: prdata = box_reg.y_high;
            default:    prdata = '0;
        endcase
    end

    rbbe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .box        (box_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .item_valid (q_push_valid),
        .item_ready (q_push_ready),
        .item       (q_push_data)
    );

    rbbe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    rbbe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_pop_valid),
        .item_ready (q_pop_ready),
        .item       (q_pop_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

/* bench/testbench.sv */
// testbench: self-checking bench for ray_box_boundary_extend_unit
// depends on rbbe_pkg and the unit; predicts each endpoint with exact integer math

module testbench;
    import rbbe_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 100;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    ray_in_t     in_data;
    logic        out_valid;
    logic        out_ready;
    ray_out_t    out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    longint   edge_x_low;
    longint   edge_x_high;
    longint   edge_y_low;
    longint   edge_y_high;
    ray_out_t expected_endpoints[$];
    int       send_idle_pct;
    int       recv_stall_pct;
    int       hold_off_cycles;
    int       mismatches;
    int       stray_transfers;
    int       quiet_cycles;

    ray_box_boundary_extend_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic longint round_div(input longint num, input longint den);
        if (num >= 0)
            return (2 * num + den) / (2 * den);
        return -((2 * (-num) + den) / (2 * den));
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic ray_out_t predict_endpoint(input ray_in_t r);
        longint   ox, oy, dx, dy;
        longint   bound, o_axis, d_axis, o_oth, d_oth, lo, hi;
        longint   n, d, off, best_n, best_d, hit_x, hit_y, other;
        bit       found;
        ray_out_t res;
        ox = longint'(r.start_x);
        oy = longint'(r.start_y);
        dx = longint'(r.heading_x);
        dy = longint'(r.heading_y);
        found = 1'b0;
        best_n = 0;
        best_d = 1;
        hit_x = 0;
        hit_y = 0;
        // sides in order left, right, bottom, top
        for (int s = 0; s < 4; s++)
        begin
            case (s)
                0: bound = edge_x_low;
                1: bound = edge_x_high;
                2: bound = edge_y_low;
                default: bound = edge_y_high;
            endcase
            o_axis = (s < 2) ? ox : oy;
            d_axis = (s < 2) ? dx : dy;
            o_oth  = (s < 2) ? oy : ox;
            d_oth  = (s < 2) ? dy : dx;
            lo     = (s < 2) ? edge_y_low : edge_x_low;
            hi     = (s < 2) ? edge_y_high : edge_x_high;
            if (d_axis == 0)
                continue;
            n = bound - o_axis;
            d = d_axis;
            if (d < 0)
            begin
                n = -n;
                d = -d;
            end
            if (n <= 0)
                continue;
            off = n * d_oth;
            if (off < (lo - o_oth) * d || off > (hi - o_oth) * d)
                continue;
            if (found && !(n * best_d < best_n * d))
                continue;
            other = o_oth + round_div(off, d);
            found = 1'b1;
            best_n = n;
            best_d = d;
            hit_x = (s < 2) ? bound : other;
            hit_y = (s < 2) ? other : bound;
        end
        res.hit = found;
        res.end_x = found ? 32'(clamp32(hit_x)) : r.start_x;
        res.end_y = found ? 32'(clamp32(hit_y)) : r.start_y;
        return res;
    endfunction

    // result checker and receiver stall control
    always @(posedge clk)
    begin
        ray_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_endpoints.size() == 0)
            begin
                stray_transfers++;
                $display("unexpected output transfer: %h", out_data);
            end
            else
            begin
                want = expected_endpoints.pop_front();
                if (out_data.end_x !== want.end_x || out_data.end_y !== want.end_y
                    || out_data.hit !== want.hit)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected x=%0d y=%0d hit=%0b, got x=%0d y=%0d hit=%0b",
                                 want.end_x, want.end_y, want.hit,
                                 out_data.end_x, out_data.end_y, out_data.hit);
                end
            end
        end
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= (($urandom % 100) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_ray(input ray_in_t r);
        while (($urandom % 100) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= r;
        do
            @(posedge clk);
        while (!in_ready);
        expected_endpoints = {expected_endpoints, predict_endpoint(r)};
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_endpoints.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_edge(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_X_LOW:  edge_x_low  = longint'(signed'(value));
            REG_X_HIGH: edge_x_high = longint'(signed'(value));
            REG_Y_LOW:  edge_y_low  = longint'(signed'(value));
            default:    edge_y_high = longint'(signed'(value));
        endcase
    endtask

    task automatic set_box(input int xl, input int xh, input int yl, input int yh);
        wait_drained();
        write_edge(REG_X_LOW, xl);
        write_edge(REG_X_HIGH, xh);
        write_edge(REG_Y_LOW, yl);
        write_edge(REG_Y_HIGH, yh);
    endtask

    function automatic ray_in_t make_ray(input int ox, input int oy, input int hx, input int hy);
        ray_in_t r;
        r.start_x = ox;
        r.start_y = oy;
        r.heading_x = hx[15:0];
        r.heading_y = hy[15:0];
        return r;
    endfunction

    function automatic int pick_coord(input longint lo, input longint hi);
        longint span, a, b;
        if ($urandom % 5 == 0)
            return $urandom;
        a = (lo < hi) ? lo : hi;
        b = (lo < hi) ? hi : lo;
        span = b - a;
        a = a - span / 4;
        span = span + span / 2 + 1;
        if (span > 64'd4294967295)
            return $urandom;
        return int'(clamp32(a + longint'({$urandom, $urandom}) % span));
    endfunction

    function automatic int pick_heading();
        case ($urandom % 10)
            0: return 0;
            1, 2: return $urandom;
            default: return int'($urandom_range(32768)) - 16384;
        endcase
    endfunction

    function automatic ray_in_t random_ray();
        return make_ray(pick_coord(edge_x_low, edge_x_high), pick_coord(edge_y_low, edge_y_high),
                        pick_heading(), pick_heading());
    endfunction

    task automatic test_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_ray(make_ray(32'h0010_0000, 32'h0010_0000, 0, 0));
        send_ray(make_ray(32'h0010_0000, 32'h0010_0000, 16384, 0));
        send_ray(make_ray(32'h0010_0000, 32'h0010_0000, -16384, 0));
        send_ray(make_ray(32'h0010_0000, 32'h0010_0000, 0, 16384));
        send_ray(make_ray(32'h0010_0000, 32'h0010_0000, 0, -16384));
        send_ray(make_ray(0, 32'h0010_0000, -16384, 0));
        send_ray(make_ray(0, 32'h0010_0000, 16384, 0));
        send_ray(make_ray(32'hFFF0_0000, 32'hFFF0_0000, 11585, 11585));
        send_ray(make_ray(32'h0001_0000, 32'hFFF8_0000, -16384, -16384));
        send_ray(make_ray(32'h8000_0000, 32'h8000_0000, 16384, 16384));
        send_ray(make_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, -16384, -16384));
        send_ray(make_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF, 32'h8000));
        send_ray(make_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000, 32'h7FFF));
        send_ray(make_ray(32'h0020_0000, 32'h0020_0000, 1, 32'hFFFF));
        send_ray(make_ray(32'h0020_0000, 32'h0020_0000, 12345, -9876));
        send_ray(make_ray(32'h0120_0000, 32'h0010_0000, 16384, 5));
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
            send_ray(random_ray());
    endtask

    task automatic test_box_settings();
        send_idle_pct = 10;
        recv_stall_pct = 10;
        set_box(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        test_directed();
        run_random(30);
        // tiny box far away at the edge of the coordinate range
        set_box(32'h7FFF_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_FFFF);
        send_ray(make_ray(32'h7FFE_0000, 32'h8000_8000, 16384, 1));
        run_random(30);
        // misordered x, then misordered y
        set_box(32'h0010_0000, 32'hFFF0_0000, 32'hFFF0_0000, 32'h0010_0000);
        run_random(30);
        set_box(32'hFFF0_0000, 32'h0010_0000, 32'h0010_0000, 32'hFFF0_0000);
        run_random(30);
        // zero-size box
        set_box(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_ray(make_ray(0, 0, 16384, 16384));
        run_random(30);
        set_box(32'hFFC0_0000, 32'h0050_0000, 32'hFFE0_0000, 32'h0030_0000);
    endtask

    task automatic test_idle_phases();
        send_idle_pct = 0;  recv_stall_pct = 0;  run_random(220);
        send_idle_pct = 68; recv_stall_pct = 0;  run_random(220);
        send_idle_pct = 0;  recv_stall_pct = 68; run_random(220);
        send_idle_pct = 8;  recv_stall_pct = 8;  run_random(150);
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drained();
        hold_off_cycles <= 400;
        run_random(150);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_off_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mismatches = 0;
        stray_transfers = 0;
        quiet_cycles = 0;
        edge_x_low = longint'(signed'(RST_X_LOW));
        edge_x_high = longint'(signed'(RST_X_HIGH));
        edge_y_low = longint'(signed'(RST_Y_LOW));
        edge_y_high = longint'(signed'(RST_Y_HIGH));
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_box_settings();
        test_idle_phases();
        test_backpressure();
        wait_drained();
        if (mismatches == 0 && stray_transfers == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* filelist.f */
src/rbbe_pkg.sv
src/rbbe_front.sv
src/rbbe_queue.sv
src/rbbe_back.sv
src/ray_box_boundary_extend_unit.sv
bench/testbench.sv
